FILE: design/sortuq_pkg.sv
// ----------------------------------------------------------------------------
// sortuq_pkg: shared types and constants
// Store capacity, queue sizing and the queue entry that passes from the front
// end to the sorting back end.
// ----------------------------------------------------------------------------
package sortuq_pkg;

   localparam int CAPACITY    = 32;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [31:0] value_type;

   typedef struct packed {
      value_type value;
      logic      last;
      logic      keep;
      logic      overflow;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

endpackage

FILE: design/sortuq_front.sv
// ----------------------------------------------------------------------------
// sortuq_front: transaction intake
// Counts the values of the current batch, marks each as kept or dropped and
// tracks the batch overflow flag.
// ----------------------------------------------------------------------------
module sortuq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  sortuq_pkg::value_type value,
   input  logic                  last,
   output sortuq_pkg::entry_type entry
);
   import sortuq_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             keep;

   assign keep = (count_ff < CNT_W'(CAPACITY));

   assign entry.value    = value;
   assign entry.last     = last;
   assign entry.keep     = keep;
   assign entry.overflow = drop_ff | ~keep;

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
            drop_in  = 1'b0;
         end else begin
            if (keep) count_in = count_ff + CNT_W'(1);
            drop_in = drop_ff | ~keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

FILE: design/sortuq_queue.sv
// ----------------------------------------------------------------------------
// sortuq_queue: decoupling queue
// Small FIFO between intake and the sorting back end.
// ----------------------------------------------------------------------------
module sortuq_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sortuq_pkg::entry_type      push_entry,
   input  logic                       pop,
   output sortuq_pkg::queue_head_type head,
   output logic                       full
);
   import sortuq_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full       = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   assign do_push = push & ~full;
   assign do_pop  = pop & head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      if (do_pop)  rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      priority if (do_push && !do_pop) fill_in = fill_ff + QCNT_W'(1);
      else if (do_pop && !do_push)     fill_in = fill_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: design/sortuq_back.sv
// ----------------------------------------------------------------------------
// sortuq_back: insertion chain and drain
// Inserts each kept value into a sorted chain of distinct values, one per
// cycle outside a drain; the last transaction drains the chain one per cycle.
// ----------------------------------------------------------------------------
module sortuq_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sortuq_pkg::queue_head_type head,
   output logic                       pop,
   output logic                       rsp_strobe,
   output sortuq_pkg::value_type      rsp_value_res,
   output logic                       rsp_last_res,
   output logic                       rsp_overflow
);
   import sortuq_pkg::*;

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   value_type           cell_ff [CAPACITY];
   value_type           cell_in [CAPACITY];
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic                state_ff, state_in;
   logic                overflow_ff, overflow_in;
   logic [CAPACITY-1:0] lt, eq;
   logic                dup;
   value_type           v;

   assign v   = head.entry.value;
   assign pop = head.valid & (state_ff == ST_FILL);

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt[i] = valid_ff[i] & (cell_ff[i] < v);
         eq[i] = valid_ff[i] & (cell_ff[i] == v);
      end
   end
   assign dup = |eq;

   always_comb begin
      cell_in     = cell_ff;
      valid_in    = valid_ff;
      state_in    = state_ff;
      overflow_in = overflow_ff;
      if (state_ff == ST_DRAIN) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_in[i]  = cell_ff[i+1];
            valid_in[i] = valid_ff[i+1];
         end
         valid_in[CAPACITY-1] = 1'b0;
         if (!valid_ff[1]) state_in = ST_FILL;
      end else if (head.valid) begin
         if (head.entry.keep && !dup) begin
            if (!lt[0]) begin
               cell_in[0]  = v;
               valid_in[0] = 1'b1;
            end
            for (int i = 1; i < CAPACITY; i++) begin
               if (!lt[i]) begin
                  if (lt[i-1]) begin
                     cell_in[i]  = v;
                     valid_in[i] = 1'b1;
                  end else begin
                     cell_in[i]  = cell_ff[i-1];
                     valid_in[i] = valid_ff[i-1];
                  end
               end
            end
         end
         if (head.entry.last) begin
            state_in    = ST_DRAIN;
            overflow_in = head.entry.overflow;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      overflow_ff <= overflow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         state_ff <= ST_FILL;
      end else begin
         valid_ff <= valid_in;
         state_ff <= state_in;
      end
   end

   assign rsp_strobe    = (state_ff == ST_DRAIN);
   assign rsp_value_res = cell_ff[0];
   assign rsp_last_res  = ~valid_ff[1];
   assign rsp_overflow  = overflow_ff;

   // chain occupancy is contiguous from the head
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & (valid_ff + CAPACITY'(1))) == '0)
      else $error("chain valid bits not contiguous");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> valid_ff[0])
      else $error("drain with empty chain");

   a_strictly_sorted: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (cell_ff[0] < cell_ff[1]))
      else $error("chain head not strictly ascending");

   a_back_to_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_res) |=> (state_ff == ST_FILL) && (valid_ff == '0))
      else $error("chain not empty after final result");

endmodule

FILE: design/sort_unique_batch_core.sv
// ----------------------------------------------------------------------------
// sort_unique_batch_core: sort a batch and remove duplicates
// Result path: with the queue otherwise empty, a batch's final value is
//   queued, then inserted as the drain starts; results follow one per cycle.
// Throughput: one transaction per cycle while the insertion chain fills; during
//   a drain of k results the 4-entry queue absorbs input, then busy rises.
// Reset clears counters, queue and chain valid bits; the receiver
//   cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sort_unique_batch_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sortuq_pkg::value_type req_value,
   input  logic                  req_last,
   output logic                  rsp_strobe,
   output sortuq_pkg::value_type rsp_value_res,
   output logic                  rsp_last_res,
   output logic                  rsp_overflow
);
   import sortuq_pkg::*;

   logic           accept;
   logic           full;
   logic           pop;
   entry_type      entry;
   queue_head_type head;

   assign busy   = full;
   assign accept = start & ~full;

   sortuq_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .value  (req_value),
      .last   (req_last),
      .entry  (entry)
   );

   sortuq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .full       (full)
   );

   sortuq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow)
   );

endmodule
